// File: hw/rtl/variable_width_glyph_blitter_top_defines.svh
// Assertion macros shared by the glyph blitter RTL.
// Define ASSERT_OFF to compile every check out; no other dependencies.
`ifndef VARIABLE_WIDTH_GLYPH_BLITTER_TOP_DEFINES_SVH
`define VARIABLE_WIDTH_GLYPH_BLITTER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// Checked on every clock edge outside reset.
`define VWGB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define VWGB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VWGB_ASSERT(lbl, clk, rst, prop, msg)
`define VWGB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: hw/rtl/vwgb_pkg.sv
// Shared types, constants and the glyph font table of the glyph blitter.
// Used by vwgb_front, vwgb_queue, vwgb_back and the top level; no dependencies.
package vwgb_pkg;

   localparam int SCREEN_WIDTH_DEF  = 128;
   localparam int SCREEN_HEIGHT_DEF = 64;

   localparam int CHAR_W     = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;
   localparam int COL_W      = 3;
   localparam int COL_BITS_W = 6;
   localparam int ADDR_W     = 16;
   localparam int RSP_DATA_W = 40;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] NEWLINE_CODE = 8'd10;
   // Codes in this range fold onto the upper-case glyphs
   localparam logic [7:0] FOLD_FIRST   = 8'd96;
   localparam logic [7:0] FOLD_LAST    = 8'd127;
   localparam logic [5:0] SEL_WIDE_MASK   = 6'h3f;
   localparam logic [5:0] SEL_NARROW_MASK = 6'h1f;
   localparam int MARK_FIVE_BIT = 6;
   localparam int MARK_LAST_BIT = 7;
   localparam logic [COL_W-1:0] MAX_COLS  = 3'd5;
   localparam logic [COL_W-1:0] FIFTH_COL = 3'd4;

   localparam logic [7:0] START_X_RST        = 8'd0;
   localparam logic [7:0] START_Y_RST        = 8'd0;
   localparam logic [3:0] LETTER_SPACING_RST = 4'd1;
   localparam logic [5:0] LINE_HEIGHT_RST    = 6'd8;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_START_X        = 3'd0,
      REG_START_Y        = 3'd1,
      REG_LETTER_SPACING = 3'd2,
      REG_LINE_HEIGHT    = 3'd3,
      REG_INVERT_MODE    = 3'd4
   } reg_index_type;

   // One glyph to draw, handed from the front to the back
   typedef struct packed {
      logic [5:0]        glyph;
      logic [ADDR_W-1:0] idx;
      logic [2:0]        off;
      logic              clear;
      logic [COL_W-1:0]  ncols;
   } blit_cmd_type;

   localparam logic [7:0] GLYPH_ROM [256] = '{
      8'h1E,8'h21,8'h2D,8'hAE, 8'h3E,8'h09,8'hBE,8'h00,
      8'h3F,8'h25,8'h9A,8'h00, 8'h1E,8'h21,8'hA1,8'h00,
      8'h3F,8'h21,8'h9E,8'h00, 8'h3F,8'h25,8'hA1,8'h00,
      8'h3F,8'h05,8'h81,8'h00, 8'h1E,8'h21,8'h29,8'h98,
      8'h3F,8'h04,8'hBF,8'h00, 8'h21,8'h3F,8'hA1,8'h00,
      8'h10,8'h20,8'h9F,8'h00, 8'h3F,8'h04,8'hBB,8'h00,
      8'h3F,8'h20,8'hA0,8'h00, 8'h7F,8'hC2,8'hC4,8'hC2,
      8'h3F,8'h02,8'h04,8'hBF, 8'h1E,8'h21,8'h21,8'h9E,
      8'h3F,8'h09,8'h86,8'h00, 8'h1E,8'h21,8'h11,8'hAE,
      8'h3F,8'h09,8'hB6,8'h00, 8'h22,8'h25,8'h99,8'h00,
      8'h01,8'h3F,8'h81,8'h00, 8'h1F,8'h20,8'h20,8'h9F,
      8'h0F,8'h30,8'h8F,8'h00, 8'h7F,8'hD0,8'hC8,8'hD0,
      8'h3B,8'h04,8'hBB,8'h00, 8'h07,8'h38,8'h87,8'h00,
      8'h31,8'h29,8'h25,8'hA3, 8'h3F,8'h21,8'hA1,8'h00,
      8'h03,8'h0C,8'hB0,8'h00, 8'h21,8'h21,8'hBF,8'h00,
      8'h02,8'h01,8'h82,8'h00, 8'h20,8'h20,8'hA0,8'h00,
      8'h80,8'h00,8'h00,8'h00, 8'hAF,8'h00,8'h00,8'h00,
      8'h03,8'h00,8'h83,8'h00, 8'h52,8'hBF,8'h12,8'h7F,
      8'h52,8'h55,8'hBF,8'h15, 8'h31,8'h0C,8'hA3,8'h00,
      8'h1A,8'h25,8'h1A,8'hA8, 8'h83,8'h00,8'h00,8'h00,
      8'h1E,8'hA1,8'h00,8'h00, 8'h21,8'h9E,8'h00,8'h00,
      8'h14,8'h08,8'h94,8'h00, 8'h08,8'h1C,8'h88,8'h00,
      8'h20,8'h90,8'h00,8'h00, 8'h08,8'h08,8'h88,8'h00,
      8'hA0,8'h00,8'h00,8'h00, 8'h30,8'h0C,8'h83,8'h00,
      8'h1E,8'h21,8'h9E,8'h00, 8'hBF,8'h00,8'h00,8'h00,
      8'h32,8'h29,8'hA6,8'h00, 8'h21,8'h25,8'h9A,8'h00,
      8'h0F,8'h08,8'h3F,8'h88, 8'h27,8'h25,8'h99,8'h00,
      8'h1E,8'h25,8'h98,8'h00, 8'h01,8'h39,8'h87,8'h00,
      8'h1A,8'h25,8'h9A,8'h00, 8'h06,8'h29,8'h9E,8'h00,
      8'h94,8'h00,8'h00,8'h00, 8'h20,8'h94,8'h00,8'h00,
      8'h08,8'h14,8'hA2,8'h00, 8'h14,8'h14,8'h94,8'h00,
      8'h22,8'h14,8'h88,8'h00, 8'h01,8'h29,8'h86,8'h00
   };

endpackage

// File: hw/rtl/variable_width_glyph_blitter_top.sv
// Top level of the variable-width glyph blitter: front, command queue, back.
// Uses vwgb_pkg, vwgb_front, vwgb_queue and vwgb_back.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_tvalid/req_tready  tdata[7:0] char_code
//   rsp_      out        rsp_tvalid/rsp_tready  tdata: write fields, tuser: clear_mode,
//                                               tlast: last_column
//   csr_      in         csr_valid/csr_ready    csr_index register, csr_data value
//
// A glyph of n columns (1 to 5) leaves the back one column per cycle through the output
// register while the output is free; a newline is accepted and sends nothing.
// The front accepts a character per cycle while the two-entry command queue has room.
// rsp_tready low holds the output register and the column walk; the front runs ahead.
// reset is synchronous and clears cursor, registers, queue and output valid.
module variable_width_glyph_blitter_top #(
   parameter int SCREEN_WIDTH  = vwgb_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = vwgb_pkg::SCREEN_HEIGHT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [vwgb_pkg::CHAR_W-1:0]     req_tdata,   // [7:0] char_code
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [9:0] top_address, [17:10] top_bits, [18] top_valid, [28:19] bottom_address,
   // [36:29] bottom_bits, [37] bottom_valid, [39:38] zero
   output logic [vwgb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tuser,   // [0] clear_mode
   output logic                            rsp_tlast,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [vwgb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [vwgb_pkg::CSR_DATA_W-1:0] csr_data
);

   vwgb_pkg::blit_cmd_type push_cmd;
   vwgb_pkg::blit_cmd_type head_cmd;
   logic                   q_push;
   logic                   q_full;
   logic                   q_pop;
   logic                   q_valid;

   vwgb_front #(
      .SCREEN_WIDTH (SCREEN_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .q_push     (q_push),
      .q_cmd      (push_cmd),
      .q_full     (q_full)
   );

   vwgb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .head      (head_cmd),
      .not_empty (q_valid)
   );

   vwgb_back #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_head     (head_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: hw/rtl/vwgb_front.sv
// Front end: accepts character items, holds config registers and the cursor,
// and turns each character other than newline into a blit command. Uses vwgb_pkg.
module vwgb_front #(
   parameter int SCREEN_WIDTH = vwgb_pkg::SCREEN_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [vwgb_pkg::CHAR_W-1:0]     req_tdata,   // [7:0] char_code
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [vwgb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [vwgb_pkg::CSR_DATA_W-1:0] csr_data,
   output logic                            q_push,
   output vwgb_pkg::blit_cmd_type          q_cmd,
   input  logic                            q_full
);

   localparam logic [vwgb_pkg::ADDR_W-1:0] SW16 = vwgb_pkg::ADDR_W'(SCREEN_WIDTH);

   logic [7:0] start_x_ff, start_x_in;
   logic [7:0] start_y_ff, start_y_in;
   logic [3:0] spacing_ff, spacing_in;
   logic [5:0] line_height_ff, line_height_in;
   logic       invert_ff, invert_in;
   logic [7:0] cursor_x_ff, cursor_x_in;
   logic [7:0] cursor_y_ff, cursor_y_in;

   logic                            accept;
   logic                            is_newline;
   logic                            fold;
   logic [5:0]                      glyph;
   logic [7:0]                      b0, b1, b2, b3;
   logic [vwgb_pkg::COL_W-1:0]      ncols;
   logic [vwgb_pkg::ADDR_W-1:0]     page16;
   logic [vwgb_pkg::ADDR_W-1:0]     x16;

   assign req_tready = !q_full;
   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid && req_tready;
   assign is_newline = (req_tdata == vwgb_pkg::NEWLINE_CODE);

   always_comb begin
      fold  = req_tdata inside {[vwgb_pkg::FOLD_FIRST:vwgb_pkg::FOLD_LAST]};
      glyph = req_tdata[5:0] & (fold ? vwgb_pkg::SEL_NARROW_MASK : vwgb_pkg::SEL_WIDE_MASK);
   end

   assign b0 = vwgb_pkg::GLYPH_ROM[{glyph, 2'd0}];
   assign b1 = vwgb_pkg::GLYPH_ROM[{glyph, 2'd1}];
   assign b2 = vwgb_pkg::GLYPH_ROM[{glyph, 2'd2}];
   assign b3 = vwgb_pkg::GLYPH_ROM[{glyph, 2'd3}];

   // Width: first byte flagged last ends the glyph; forced wide or no flag gives five columns
   always_comb begin
      if (b0[vwgb_pkg::MARK_FIVE_BIT]) begin
         ncols = vwgb_pkg::MAX_COLS;
      end else if (b0[vwgb_pkg::MARK_LAST_BIT]) begin
         ncols = 3'd1;
      end else if (b1[vwgb_pkg::MARK_LAST_BIT]) begin
         ncols = 3'd2;
      end else if (b2[vwgb_pkg::MARK_LAST_BIT]) begin
         ncols = 3'd3;
      end else if (b3[vwgb_pkg::MARK_LAST_BIT]) begin
         ncols = 3'd4;
      end else begin
         ncols = vwgb_pkg::MAX_COLS;
      end
   end

   // Page row is the signed cursor row divided by eight
   assign page16 = {{11{cursor_y_ff[7]}}, cursor_y_ff[7:3]};
   assign x16    = {{8{cursor_x_ff[7]}}, cursor_x_ff};

   always_comb begin
      q_cmd.glyph = glyph;
      q_cmd.idx   = vwgb_pkg::ADDR_W'(page16 * SW16) + x16;
      q_cmd.off   = cursor_y_ff[2:0];
      q_cmd.clear = invert_ff;
      q_cmd.ncols = ncols;
   end

   assign q_push = accept && !is_newline;

   always_comb begin
      start_x_in     = start_x_ff;
      start_y_in     = start_y_ff;
      spacing_in     = spacing_ff;
      line_height_in = line_height_ff;
      invert_in      = invert_ff;
      cursor_x_in    = cursor_x_ff;
      cursor_y_in    = cursor_y_ff;
      if (accept) begin
         if (is_newline) begin
            cursor_x_in = start_x_ff;
            cursor_y_in = cursor_y_ff + {2'b00, line_height_ff};
         end else begin
            cursor_x_in = cursor_x_ff + 8'(ncols) + {4'b0000, spacing_ff};
         end
      end
      if (csr_valid && csr_ready) begin
         case (vwgb_pkg::reg_index_type'(csr_index))
            vwgb_pkg::REG_START_X: begin
               start_x_in  = csr_data;
               cursor_x_in = csr_data;
            end
            vwgb_pkg::REG_START_Y: begin
               start_y_in  = csr_data;
               cursor_y_in = csr_data;
            end
            vwgb_pkg::REG_LETTER_SPACING: spacing_in     = csr_data[3:0];
            vwgb_pkg::REG_LINE_HEIGHT:    line_height_in = csr_data[5:0];
            vwgb_pkg::REG_INVERT_MODE:    invert_in      = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff     <= vwgb_pkg::START_X_RST;
         start_y_ff     <= vwgb_pkg::START_Y_RST;
         spacing_ff     <= vwgb_pkg::LETTER_SPACING_RST;
         line_height_ff <= vwgb_pkg::LINE_HEIGHT_RST;
         invert_ff      <= 1'b0;
         cursor_x_ff    <= 8'd0;
         cursor_y_ff    <= 8'd0;
      end else begin
         start_x_ff     <= start_x_in;
         start_y_ff     <= start_y_in;
         spacing_ff     <= spacing_in;
         line_height_ff <= line_height_in;
         invert_ff      <= invert_in;
         cursor_x_ff    <= cursor_x_in;
         cursor_y_ff    <= cursor_y_in;
      end
   end

endmodule

// File: hw/rtl/vwgb_queue.sv
// Short command queue between the front and the back of the glyph blitter.
// Uses vwgb_pkg and the assertion macros header.
`include "variable_width_glyph_blitter_top_defines.svh"
module vwgb_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  vwgb_pkg::blit_cmd_type push_cmd,
   output logic                   full,
   input  logic                   pop,
   output vwgb_pkg::blit_cmd_type head,
   output logic                   not_empty
);

   localparam int DEPTH = vwgb_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   vwgb_pkg::blit_cmd_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == DEPTH_CNT);
   assign not_empty = (count_ff != '0);
   assign head      = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `VWGB_ASSERT(a_queue_no_overflow, clock, reset, push |-> !full || pop, "push into full queue")
   `VWGB_ASSERT(a_queue_count_bound, clock, reset, count_ff <= DEPTH_CNT, "queue count beyond depth")

endmodule

// File: hw/rtl/vwgb_back.sv
// Back end: walks the columns of one blit command, one per cycle while the output is free,
// and registers each masked framebuffer write. Uses vwgb_pkg and the macros header.
`include "variable_width_glyph_blitter_top_defines.svh"
module vwgb_back #(
   parameter int SCREEN_WIDTH  = vwgb_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = vwgb_pkg::SCREEN_HEIGHT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   input  vwgb_pkg::blit_cmd_type          q_head,
   output logic                            q_pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [9:0] top_address, [17:10] top_bits, [18] top_valid, [28:19] bottom_address,
   // [36:29] bottom_bits, [37] bottom_valid, [39:38] zero
   output logic [vwgb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tuser,   // [0] clear_mode
   output logic                            rsp_tlast
);

   localparam int LIMIT = SCREEN_WIDTH * (SCREEN_HEIGHT / 8);
   localparam int WIDE_W = vwgb_pkg::ADDR_W + 1;
   localparam logic [WIDE_W-1:0] LIMIT_W = WIDE_W'(LIMIT);
   localparam logic [WIDE_W-1:0] SW_W    = WIDE_W'(SCREEN_WIDTH);

   typedef enum logic [1:0] {
      BK_IDLE = 2'b01,
      BK_RUN  = 2'b10
   } back_state_type;

   back_state_type                   state_ff, state_in;
   vwgb_pkg::blit_cmd_type           cmd_ff, cmd_in;
   logic [vwgb_pkg::COL_W-1:0]       col_ff, col_in;
   logic [vwgb_pkg::ADDR_W-1:0]      idx_ff, idx_in;
   logic [vwgb_pkg::COL_BITS_W-1:0]  fifth_ff, fifth_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [vwgb_pkg::RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                             rsp_user_ff, rsp_user_in;
   logic                             rsp_last_ff, rsp_last_in;

   logic                             running;
   vwgb_pkg::blit_cmd_type           cur_cmd;
   logic [vwgb_pkg::COL_W-1:0]       cur_col;
   logic [vwgb_pkg::ADDR_W-1:0]      cur_idx;
   logic [vwgb_pkg::COL_BITS_W-1:0]  cur_fifth;
   logic                             active;
   logic                             out_free;
   logic                             emit;
   logic                             last;
   logic [7:0]                       rom_data;
   logic [vwgb_pkg::COL_BITS_W-1:0]  col_bits;
   logic [13:0]                      shifted;
   logic [WIDE_W-1:0]                top_w;
   logic [WIDE_W-1:0]                low_w;
   logic                             top_valid;
   logic                             bottom_valid;

   assign running   = (state_ff == BK_RUN);
   assign cur_cmd   = running ? cmd_ff : q_head;
   assign cur_col   = running ? col_ff : '0;
   assign cur_idx   = running ? idx_ff : q_head.idx;
   assign cur_fifth = running ? fifth_ff : '0;
   assign active    = running || q_valid;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign emit      = active && out_free;
   assign q_pop     = emit && !running;

   assign rom_data = vwgb_pkg::GLYPH_ROM[{cur_cmd.glyph, cur_col[1:0]}];
   // Fifth column gathers bits 7..6 of bytes 1 to 3
   assign col_bits = (cur_col == vwgb_pkg::FIFTH_COL) ? cur_fifth
                                                       : rom_data[vwgb_pkg::COL_BITS_W-1:0];
   assign last     = (cur_col == cur_cmd.ncols - 3'd1);

   // Bits above the byte are what spills into the page below
   assign shifted      = {8'd0, col_bits} << cur_cmd.off;
   assign top_w        = {1'b0, cur_idx};
   assign low_w        = top_w + SW_W;
   assign top_valid    = (top_w < LIMIT_W);
   assign bottom_valid = (cur_cmd.off > 3'd1) && (low_w < LIMIT_W);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      col_in       = col_ff;
      idx_in       = idx_ff;
      fifth_in     = fifth_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {2'b00, bottom_valid, {2'b00, shifted[13:8]}, low_w[9:0],
                         top_valid, shifted[7:0], cur_idx[9:0]};
         rsp_user_in  = cur_cmd.clear;
         rsp_last_in  = last;
         state_in     = last ? BK_IDLE : BK_RUN;
         cmd_in       = cur_cmd;
         col_in       = cur_col + 3'd1;
         idx_in       = cur_idx + 16'd1;
         fifth_in     = {rom_data[7:6], cur_fifth[vwgb_pkg::COL_BITS_W-1:2]};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      col_ff      <= col_in;
      idx_ff      <= idx_in;
      fifth_ff    <= fifth_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   `VWGB_ASSERT(a_back_pop_has_item, clock, reset, q_pop |-> q_valid, "pop from empty queue")
   `VWGB_ASSERT(a_back_last_ends_glyph, clock, reset, emit && last |=> state_ff == BK_IDLE, "glyph run continues past last column")
   `VWGB_ASSERT(a_back_column_range, clock, reset, running |-> (col_ff != 3'd0) && (col_ff < cmd_ff.ncols), "column index outside glyph")
   `VWGB_ASSERT_ALWAYS(a_back_reset_clears, clock, reset |=> !rsp_tvalid, "result valid after reset")

endmodule
